/* hw/rtl/yc48_pkg.sv */
// Shared types and constants of the YUY2 to YC48 line converter.
`default_nettype none

package yc48_pkg;

    localparam int LUMA_GAIN    = 1197;
    localparam int LUMA_OFFSET  = 299;
    localparam int CHROMA_GAIN  = 4682;
    localparam int CHROMA_ROUND = 128;
    localparam int CHROMA_BIAS  = 2341;
    localparam int CHROMA_W     = 13;
    localparam int QUEUE_DEPTH  = 4;

    // One classified group on its way to the pixel stage; chroma is biased (non-negative).
    typedef struct packed {
        logic                has_held;
        logic                eol;
        logic [7:0]          held_luma;
        logic [7:0]          even_luma;
        logic [7:0]          odd_luma;
        logic [CHROMA_W-1:0] cb_mid;
        logic [CHROMA_W-1:0] cr_mid;
        logic [CHROMA_W-1:0] cb_new;
        logic [CHROMA_W-1:0] cr_new;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        PIX_HELD,
        PIX_EVEN,
        PIX_ODD
    } t_pix_sel;

endpackage

`default_nettype wire

/* hw/rtl/yc48_front.sv */
// Front end: accepts YUY2 groups, holds the odd half and builds pixel commands.
`default_nettype none

module yc48_front
    import yc48_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_first_luma,
    input  wire logic [7:0]    i_blue_diff,
    input  wire logic [7:0]    i_second_luma,
    input  wire logic [7:0]    i_red_diff,
    input  wire logic          i_line_end,
    input  wire t_queue_status i_status,
    output logic               o_cmd_push,
    output t_cmd               o_cmd
);

    function automatic logic [CHROMA_W-1:0] f_chroma_biased(input logic [7:0] c);
        logic [20:0] prod;
        prod = 21'(c) * 21'(CHROMA_GAIN) + 21'(CHROMA_ROUND);
        return prod[20:8];
    endfunction

    logic                r_holding;
    logic [7:0]          r_held_luma;
    logic [CHROMA_W-1:0] r_held_cb;
    logic [CHROMA_W-1:0] r_held_cr;

    logic [CHROMA_W-1:0] cb_new;
    logic [CHROMA_W-1:0] cr_new;
    logic [CHROMA_W:0]   cb_sum;
    logic [CHROMA_W:0]   cr_sum;

    assign cb_new     = f_chroma_biased(i_blue_diff);
    assign cr_new     = f_chroma_biased(i_red_diff);
    assign cb_sum     = {1'b0, r_held_cb} + {1'b0, cb_new};
    assign cr_sum     = {1'b0, r_held_cr} + {1'b0, cr_new};
    assign o_cmd_push = i_push && !i_status.full;

    always_comb begin
        o_cmd.has_held  = r_holding;
        o_cmd.eol       = i_line_end;
        o_cmd.held_luma = r_held_luma;
        o_cmd.even_luma = i_first_luma;
        o_cmd.odd_luma  = i_second_luma;
        o_cmd.cb_mid    = cb_sum[CHROMA_W:1];
        o_cmd.cr_mid    = cr_sum[CHROMA_W:1];
        o_cmd.cb_new    = cb_new;
        o_cmd.cr_new    = cr_new;
    end

    // Hold the odd half until the next group of the line; drop it at line end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
        end else if (o_cmd_push) begin
            r_holding <= !i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_push) begin
            r_held_luma <= i_second_luma;
            r_held_cb   <= cb_new;
            r_held_cr   <= cr_new;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/yc48_queue.sv */
// Short command queue between the front end and the pixel stage.
`default_nettype none

module yc48_queue
    import yc48_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_cmd    i_cmd,
    input  wire logic    i_pop,
    output t_cmd         o_head,
    output t_queue_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/yc48_back.sv */
// Pixel stage: expands each command into one to three YC48 pixels.
`default_nettype none

module yc48_back
    import yc48_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_head,
    input  wire t_queue_status i_status,
    output logic               o_cmd_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic signed [13:0] o_luma_out,
    output logic signed [12:0] o_cb_out,
    output logic signed [12:0] o_cr_out,
    output logic               o_pixel_last_in_line,
    output logic               o_run_last
);

    function automatic logic signed [13:0] f_luma(input logic [7:0] y);
        logic [18:0]        prod;
        logic signed [13:0] val;
        prod = 19'(y) * 19'(LUMA_GAIN);
        val  = $signed({1'b0, prod[18:6]}) - $signed(14'(LUMA_OFFSET));
        return val;
    endfunction

    function automatic logic signed [12:0] f_unbias(input logic [CHROMA_W-1:0] b);
        logic signed [13:0] val;
        val = $signed({1'b0, b}) - $signed(14'(CHROMA_BIAS));
        return val[12:0];
    endfunction

    t_pix_sel r_sel;
    t_pix_sel n_sel;
    t_pix_sel cur;

    logic                r_valid;
    logic                load;
    logic                last_of_cmd;
    logic [7:0]          y_sel;
    logic [CHROMA_W-1:0] cb_sel;
    logic [CHROMA_W-1:0] cr_sel;

    assign load    = !i_status.empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= PIX_HELD;
        end else begin
            r_sel <= n_sel;
        end
    end

    always_comb begin
        cur = r_sel;
        if (r_sel == PIX_HELD && !i_head.has_held) begin
            cur = PIX_EVEN;
        end
        y_sel       = i_head.even_luma;
        cb_sel      = i_head.cb_new;
        cr_sel      = i_head.cr_new;
        last_of_cmd = 1'b0;
        case (cur)
            PIX_HELD: begin
                y_sel  = i_head.held_luma;
                cb_sel = i_head.cb_mid;
                cr_sel = i_head.cr_mid;
            end
            PIX_EVEN: begin
                last_of_cmd = !i_head.eol;
            end
            PIX_ODD: begin
                y_sel       = i_head.odd_luma;
                last_of_cmd = 1'b1;
            end
            default: begin
                last_of_cmd = 1'b1;
            end
        endcase
        n_sel     = r_sel;
        o_cmd_pop = 1'b0;
        if (load) begin
            if (last_of_cmd) begin
                n_sel     = PIX_HELD;
                o_cmd_pop = 1'b1;
            end else if (cur == PIX_HELD) begin
                n_sel = PIX_EVEN;
            end else begin
                n_sel = PIX_ODD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_luma_out           <= f_luma(y_sel);
            o_cb_out             <= f_unbias(cb_sel);
            o_cr_out             <= f_unbias(cr_sel);
            o_pixel_last_in_line <= (cur == PIX_ODD);
            o_run_last           <= last_of_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/yuy2_to_yc48_line_converter.sv */
// Top level of the YUY2 to YC48 line converter.
`default_nettype none

// Push one packed YUY2 group (two luma bytes, U, V and a line-end flag) per
// transfer; pixels come out in line order, one per cycle while the receiver
// keeps popping and commands are queued, through a queue-like result port. A
// group causes one pixel when nothing is held (first group of a line), two in
// mid-line and two or three when it ends a line, so the sustained rate is set
// by the single-pixel result register. The front end accepts a group every
// cycle while its four-entry command queue has room, so a stalled result side
// fills the queue before full rises. Line width must be even; the held odd
// half is dropped at each line end.
module yuy2_to_yc48_line_converter
    import yc48_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_first_luma,
    input  wire logic [7:0]    i_blue_diff,
    input  wire logic [7:0]    i_second_luma,
    input  wire logic [7:0]    i_red_diff,
    input  wire logic          i_line_end,
    output logic               empty,
    input  wire logic          pop,
    output logic signed [13:0] o_luma_out,
    output logic signed [12:0] o_cb_out,
    output logic signed [12:0] o_cr_out,
    output logic               o_pixel_last_in_line,
    output logic               o_run_last
);

    t_cmd          front_cmd;
    t_cmd          head_cmd;
    t_queue_status q_status;
    logic          cmd_push;
    logic          cmd_pop;

    // Classify each group and average chroma with the held group.
    yc48_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_first_luma  (i_first_luma),
        .i_blue_diff   (i_blue_diff),
        .i_second_luma (i_second_luma),
        .i_red_diff    (i_red_diff),
        .i_line_end    (i_line_end),
        .i_status      (q_status),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd)
    );

    // Decouple the two sides so each may stall on its own.
    yc48_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_cmd    (front_cmd),
        .i_pop    (cmd_pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // Expand commands into pixels, one per cycle into the result register while it is free or being popped.
    yc48_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_head               (head_cmd),
        .i_status             (q_status),
        .o_cmd_pop            (cmd_pop),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_luma_out           (o_luma_out),
        .o_cb_out             (o_cb_out),
        .o_cr_out             (o_cr_out),
        .o_pixel_last_in_line (o_pixel_last_in_line),
        .o_run_last           (o_run_last)
    );

    assign full = q_status.full;

    // A line's final pixel always closes the run of its group.
    a_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_pixel_last_in_line) |-> o_run_last)
        else $error("last pixel of line without run_last");

    // Never push a command into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !cmd_push)
        else $error("command pushed while queue full");

    // Never take a command from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !cmd_pop)
        else $error("command popped while queue empty");

    // Reset leaves no result waiting.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result waiting after reset");

endmodule

`default_nettype wire

/* dv/yuy2_to_yc48_line_converter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the YUY2 to YC48 line converter, with its own pixel predictor.

module yuy2_to_yc48_line_converter_tb;

    // Conversion constants, kept here so the predictor stands on its own
    localparam int LUMA_GAIN    = 1197;
    localparam int LUMA_OFFSET  = 299;
    localparam int CHROMA_GAIN  = 4682;
    localparam int CHROMA_ROUND = 128;
    localparam int CHROMA_BIAS  = 2341;

    // Receiver hold-off long enough to fill the command queue and raise full
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_GROUPS   = 400;
    localparam int DRAIN_CYCLES    = 16;

    // One YUY2 group as pushed into the block
    typedef struct {
        logic [7:0] first_luma;
        logic [7:0] blue_diff;
        logic [7:0] second_luma;
        logic [7:0] red_diff;
        logic       line_end;
    } t_group;

    // One YC48 pixel as popped from the block
    typedef struct {
        logic signed [13:0] luma;
        logic signed [12:0] cb;
        logic signed [12:0] cr;
        logic               last_in_line;
        logic               run_last;
    } t_pixel;

    // Tracks the held odd half of a line and the pixels still owed by the block
    class yc48_line_tracker;
        t_pixel      expected_pixels[$];
        int unsigned mismatches;
        logic [7:0]  held_luma;
        logic [7:0]  held_blue;
        logic [7:0]  held_red;
        bit          holding;

        function new();
            mismatches = 0;
            holding    = 1'b0;
            held_luma  = '0;
            held_blue  = '0;
            held_red   = '0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        static function logic signed [13:0] scale_luma(logic [7:0] y);
            int t;
            t = ((int'(y) * LUMA_GAIN) >> 6) - LUMA_OFFSET;
            return t[13:0];
        endfunction

        // Chroma plus its bias, never negative
        static function int biased_chroma(logic [7:0] c);
            return (int'(c) * CHROMA_GAIN + CHROMA_ROUND) >> 8;
        endfunction

        function void add_pixel(logic [7:0] y, int cb_biased, int cr_biased,
                                logic last_in_line, logic run_last);
            t_pixel p;
            int     cb_val;
            int     cr_val;
            cb_val         = cb_biased - CHROMA_BIAS;
            cr_val         = cr_biased - CHROMA_BIAS;
            p.luma         = scale_luma(y);
            p.cb           = cb_val[12:0];
            p.cr           = cr_val[12:0];
            p.last_in_line = last_in_line;
            p.run_last     = run_last;
            expected_pixels.push_back(p);
        endfunction

        // Work out the pixels that one accepted group releases
        function void note_group(t_group g);
            int cb_new;
            int cr_new;
            cb_new = biased_chroma(g.blue_diff);
            cr_new = biased_chroma(g.red_diff);
            // The held odd pixel takes the mean of its own and the new chroma
            if (holding) begin
                add_pixel(held_luma,
                          (biased_chroma(held_blue) + cb_new) >> 1,
                          (biased_chroma(held_red) + cr_new) >> 1, 1'b0, 1'b0);
            end
            add_pixel(g.first_luma, cb_new, cr_new, 1'b0, !g.line_end);
            if (g.line_end) begin
                // Line end: the odd pixel repeats its own chroma, drop the hold
                add_pixel(g.second_luma, cb_new, cr_new, 1'b1, 1'b1);
                holding   = 1'b0;
                held_luma = '0;
                held_blue = '0;
                held_red  = '0;
            end else begin
                holding   = 1'b1;
                held_luma = g.second_luma;
                held_blue = g.blue_diff;
                held_red  = g.red_diff;
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected pixel: luma %0d cb %0d cr %0d last %0b run %0b",
                             got.luma, got.cb, got.cr, got.last_in_line, got.run_last);
                end
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.luma !== want.luma || got.cb !== want.cb || got.cr !== want.cr ||
                got.last_in_line !== want.last_in_line || got.run_last !== want.run_last) begin
                if (mismatches < 10) begin
                    $display("pixel mismatch: want luma %0d cb %0d cr %0d last %0b run %0b",
                             want.luma, want.cb, want.cr, want.last_in_line, want.run_last);
                    $display("                got  luma %0d cb %0d cr %0d last %0b run %0b",
                             got.luma, got.cb, got.cr, got.last_in_line, got.run_last);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk  = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_first_luma = '0;
    logic [7:0]         i_blue_diff = '0;
    logic [7:0]         i_second_luma = '0;
    logic [7:0]         i_red_diff = '0;
    logic               i_line_end = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [13:0] o_luma_out;
    logic signed [12:0] o_cb_out;
    logic signed [12:0] o_cr_out;
    logic               o_pixel_last_in_line;
    logic               o_run_last;

    yc48_line_tracker tracker = new();

    // Sender pacing and the one-off receiver hold-off request
    int unsigned burst_left = 1;
    int unsigned groups_sent = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    yuy2_to_yc48_line_converter u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_first_luma         (i_first_luma),
        .i_blue_diff          (i_blue_diff),
        .i_second_luma        (i_second_luma),
        .i_red_diff           (i_red_diff),
        .i_line_end           (i_line_end),
        .empty                (empty),
        .pop                  (pop),
        .o_luma_out           (o_luma_out),
        .o_cb_out             (o_cb_out),
        .o_cr_out             (o_cr_out),
        .o_pixel_last_in_line (o_pixel_last_in_line),
        .o_run_last           (o_run_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #1_000_000;
        $display("yuy2_to_yc48_line_converter test failed");
        $finish;
    end

    // Check every pixel transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && pop && !empty) begin
            got.luma         = o_luma_out;
            got.cb           = o_cb_out;
            got.cr           = o_cr_out;
            got.last_in_line = o_pixel_last_in_line;
            got.run_last     = o_run_last;
            tracker.check_pixel(got);
        end
    end

    // Receiver: switch periodically among four stall patterns; honour a hold-off
    // request by keeping pop low until the hold-off count runs out
    initial begin
        int unsigned cyc;
        int unsigned mode;
        int unsigned hold_left;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 3) != 0);
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    function automatic t_group make_group(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                          logic [7:0] v, logic eol);
        t_group g;
        g.first_luma  = y0;
        g.blue_diff   = u;
        g.second_luma = y1;
        g.red_diff    = v;
        g.line_end    = eol;
        return g;
    endfunction

    // Favour the extremes now and then
    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one group and hold it until the transfer; returns at the transfer edge
    task automatic send_group(input t_group g);
        push          <= 1'b1;
        i_first_luma  <= g.first_luma;
        i_blue_diff   <= g.blue_diff;
        i_second_luma <= g.second_luma;
        i_red_diff    <= g.red_diff;
        i_line_end    <= g.line_end;
        do @(posedge i_clk); while (full);
        tracker.note_group(g);
        groups_sent++;
    endtask

    // Send in bursts; after each burst drop push for a random gap
    task automatic send_paced(input t_group g);
        int unsigned gap;
        send_group(g);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic send_random_line(input int unsigned n_groups);
        t_group g;
        for (int unsigned k = 0; k < n_groups; k++) begin
            g = make_group(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                           k == n_groups - 1);
            send_paced(g);
        end
    endtask

    initial begin
        int unsigned n_groups;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-group lines at both extremes
        send_paced(make_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        send_paced(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        // Two-group line: average the extremes of chroma
        send_paced(make_group(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
        send_paced(make_group(8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1));
        // Three-group line with chroma swinging both ways
        send_paced(make_group(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
        send_paced(make_group(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
        send_paced(make_group(8'h80, 8'h7F, 8'h7F, 8'h80, 1'b1));
        // Longer line with alternating bit patterns and odd chroma sums
        send_paced(make_group(8'h01, 8'h01, 8'hFE, 8'hFE, 1'b0));
        send_paced(make_group(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0));
        send_paced(make_group(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0));
        send_paced(make_group(8'h10, 8'h02, 8'hEF, 8'hFD, 1'b0));
        send_paced(make_group(8'hFE, 8'h80, 8'h01, 8'h81, 1'b1));
        // Back-to-back single-group lines clear the hold each time
        send_paced(make_group(8'h40, 8'h20, 8'hC0, 8'hE0, 1'b1));
        send_paced(make_group(8'hC0, 8'hE0, 8'h40, 8'h20, 1'b1));

        while (groups_sent < RANDOM_GROUPS) begin
            // Once, stall the receiver and keep pushing without gaps
            if (!hold_done && groups_sent >= 120) begin
                hold_req   = 1'b1;
                hold_done  = 1'b1;
                burst_left = 48;
            end
            n_groups = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                   : $urandom_range(1, 8);
            send_random_line(n_groups);
        end
        push <= 1'b0;

        // Drain, then leave time for any stray pixel to show up
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("yuy2_to_yc48_line_converter test passed");
        end else begin
            $display("yuy2_to_yc48_line_converter test failed");
        end
        $finish;
    end

endmodule
